FILE: hdl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Types, register map and arithmetic helpers for the polyline closest segment
// block.
// ----------------------------------------------------------------------------
package pcs_pkg;

	localparam int MaxPoints = 256;
	localparam int AddrW     = 8;
	localparam int CountW    = 9;
	localparam int PaddrW    = 3;

	typedef enum logic [0:0] {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FEW      = 2'd1,
		ST_ZERO_SEG = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_VERT_TOTAL  = 1'b0,
		REG_CLOSED_PATH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic               command;
		logic [7:0]         point_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         seg_idx;
		logic [16:0]        seg_param;
		logic signed [31:0] closest_x;
		logic signed [31:0] closest_y;
		logic [31:0]        distance;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
	} res_t;

	function automatic logic [32:0] mag33(input logic [32:0] v);
		mag33 = v[32] ? (33'd0 - v) : v;
	endfunction

	// start + floor(t * d / 65536), p = t * |d|
	function automatic logic [31:0] lerp(input logic [31:0] s, input logic neg,
		input logic [65:0] p);
		logic [33:0] q;
		logic [33:0] se;
		logic [33:0] r;
		q  = p[49:16];
		se = {{2{s[31]}}, s};
		if (neg) begin
			r = se - q - {33'd0, |p[15:0]};
		end else begin
			r = se + q;
		end
		lerp = r[31:0];
	endfunction

endpackage

FILE: hdl/polyline_closest_segment.sv
// ----------------------------------------------------------------------------
// polyline_closest_segment
// Closest point on a stored polyline, walked segment by segment on one shared
// multiplier with a bit-serial divider and square root.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd): a load transfer writes one vertex
//   into the 256-entry store; a query transfer starts a walk of the path.
//   res channel (res_valid/res_ready/res): one result per command transfer.
//   APB port: register 0 vertex total at 0x0, register 1 closed_path at 0x4.
// Flow: a load, or a query with too few points, passes through S_DONE,
//   where its result is registered once the output register is free. A
//   query walks each segment through the states S_DIF to S_CMP, adds the
//   one-bit-a-cycle divider when t lies strictly inside 0..1, reads the
//   next vertex in S_RD between segments and ends in the serial square
//   root. The single 33x33 multiplier is used eight times per segment.
// Throughput: one command at a time; cmd_ready is high only while idle.
// Reset: clears the APB registers, the state and res_valid; the vertex store
//   holds whatever it held until written.
// Stall: a finished result waits in the output register; the next command
//   is taken meanwhile, and its result waits until the previous one leaves.
// ----------------------------------------------------------------------------
module polyline_closest_segment (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  pcs_pkg::cmd_t                cmd,
	output logic                         res_valid,
	input  logic                         res_ready,
	output pcs_pkg::res_t                res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pcs_pkg::PaddrW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import pcs_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_V0   = 18'h00002,
		S_RD   = 18'h00004,
		S_DIF  = 18'h00008,
		S_M1   = 18'h00010,
		S_M2   = 18'h00020,
		S_M3   = 18'h00040,
		S_M4   = 18'h00080,
		S_DOT  = 18'h00100,
		S_DIV  = 18'h00200,
		S_LX   = 18'h00400,
		S_LY   = 18'h00800,
		S_CY   = 18'h01000,
		S_Q1   = 18'h02000,
		S_Q2   = 18'h04000,
		S_CMP  = 18'h08000,
		S_SQRT = 18'h10000,
		S_DONE = 18'h20000
	} state_t;

	state_t state_q;

	logic [CountW-1:0] vert_total_q;
	logic              closed_path_q;
	logic [CountW-1:0] n_q, segs_q, seg_q;

	logic signed [31:0] mem_x [MaxPoints];
	logic signed [31:0] mem_y [MaxPoints];
	logic signed [31:0] rdx_q, rdy_q;
	logic [AddrW-1:0]   rd_addr;
	logic [CountW-1:0]  seg_nxt;

	logic signed [31:0] qx_q, qy_q, sx_q, sy_q, ex_q, ey_q, cx_q, cy_q;
	logic [32:0]        dxm_q, dym_q, pxm_q, pym_q, axm_q, aym_q;
	logic               dxs_q, dys_q, pxs_q, pys_q;
	logic [32:0]        mul_a, mul_b;
	logic [65:0]        prod_q;
	logic [66:0]        len2_q, d2_q;
	logic [65:0]        t1_q;
	logic [67:0]        rem_q;
	logic [16:0]        t_q;
	logic [3:0]         div_cnt_q;
	logic [1:0]         stat_q;

	logic               have_q;
	logic [66:0]        best_d2_q;
	logic [7:0]         best_i_q;
	logic [16:0]        best_t_q;
	logic signed [31:0] bcx_q, bcy_q, bsx_q, bsy_q, bex_q, bey_q;

	logic [67:0] sq_v_q;
	logic [36:0] sq_rem_q;
	logic [33:0] root_q;
	logic [5:0]  sq_cnt_q;

	logic        apb_wr;
	logic [32:0] dx_w, dy_w, px_w, py_w;
	logic [65:0] t2_w;
	logic        n1_w, n2_w;
	logic [66:0] dot_w;
	logic        dneg_w;
	logic [67:0] rem_sh;
	logic [66:0] d2_w;
	logic [36:0] sq_rem_sh, sq_trial;
	logic [CountW-1:0] n_w;
	logic [31:0] dist_w;

	assign pready    = 1'b1;
	assign apb_wr    = psel && penable && pwrite;
	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_VERT_TOTAL:  prdata = {{(32-CountW){1'b0}}, vert_total_q};
			REG_CLOSED_PATH: prdata = {31'd0, closed_path_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_total_q  <= '0;
			closed_path_q <= 1'b0;
		end else if (apb_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_VERT_TOTAL:  vert_total_q  <= pwdata[CountW-1:0];
				REG_CLOSED_PATH: closed_path_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// vertex store
	assign seg_nxt = seg_q + 1'b1;
	assign rd_addr = (state_q == S_IDLE || seg_nxt == n_q) ? '0 : seg_nxt[AddrW-1:0];

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready && cmd.command == CMD_LOAD) begin
			mem_x[cmd.point_index] <= cmd.point_x;
			mem_y[cmd.point_index] <= cmd.point_y;
		end
		rdx_q <= mem_x[rd_addr];
		rdy_q <= mem_y[rd_addr];
	end

	// shared multiplier
	always_comb begin
		unique case (state_q)
			S_M1:    begin mul_a = dxm_q;             mul_b = dxm_q; end
			S_M2:    begin mul_a = dym_q;             mul_b = dym_q; end
			S_M3:    begin mul_a = pxm_q;             mul_b = dxm_q; end
			S_M4:    begin mul_a = pym_q;             mul_b = dym_q; end
			S_LX:    begin mul_a = {16'd0, t_q};      mul_b = dxm_q; end
			S_LY:    begin mul_a = {16'd0, t_q};      mul_b = dym_q; end
			S_Q1:    begin mul_a = axm_q;             mul_b = axm_q; end
			S_Q2:    begin mul_a = aym_q;             mul_b = aym_q; end
			default: begin mul_a = '0;                mul_b = '0;    end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign dx_w = {rdx_q[31], rdx_q} - {sx_q[31], sx_q};
	assign dy_w = {rdy_q[31], rdy_q} - {sy_q[31], sy_q};
	assign px_w = {qx_q[31], qx_q} - {sx_q[31], sx_q};
	assign py_w = {qy_q[31], qy_q} - {sy_q[31], sy_q};

	assign t2_w = prod_q;
	assign n1_w = pxs_q != dxs_q;
	assign n2_w = pys_q != dys_q;
	always_comb begin
		if (n1_w == n2_w) begin
			dot_w  = {1'b0, t1_q} + {1'b0, t2_w};
			dneg_w = n1_w;
		end else if (t1_q >= t2_w) begin
			dot_w  = {1'b0, t1_q - t2_w};
			dneg_w = n1_w;
		end else begin
			dot_w  = {1'b0, t2_w - t1_q};
			dneg_w = n2_w;
		end
	end

	assign rem_sh    = {rem_q[66:0], 1'b0};
	assign d2_w      = d2_q + {1'b0, prod_q};
	assign sq_rem_sh = {sq_rem_q[34:0], sq_v_q[67:66]};
	assign sq_trial  = {1'b0, root_q, 2'b01};
	assign n_w       = (vert_total_q > CountW'(MaxPoints)) ? CountW'(MaxPoints)
		: vert_total_q;
	assign dist_w    = (root_q[33:32] != 2'd0) ? 32'hFFFF_FFFF : root_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_valid <= 1'b0;
		end else begin
			if (res_valid && res_ready && state_q != S_DONE) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (cmd_valid) begin
					if (cmd.command == CMD_LOAD) begin
						stat_q  <= ST_OK;
						have_q  <= 1'b0;
						state_q <= S_DONE;
					end else if (n_w < (closed_path_q ? CountW'(3) : CountW'(2))) begin
						stat_q  <= ST_FEW;
						state_q <= S_DONE;
					end else begin
						n_q     <= n_w;
						segs_q  <= closed_path_q ? n_w : n_w - 1'b1;
						seg_q   <= '0;
						qx_q    <= cmd.query_x;
						qy_q    <= cmd.query_y;
						have_q  <= 1'b0;
						state_q <= S_V0;
					end
				end
				S_V0: begin
					sx_q    <= rdx_q;
					sy_q    <= rdy_q;
					state_q <= S_DIF;
				end
				S_RD: state_q <= S_DIF;
				S_DIF: begin
					ex_q  <= rdx_q;
					ey_q  <= rdy_q;
					dxm_q <= mag33(dx_w);
					dym_q <= mag33(dy_w);
					pxm_q <= mag33(px_w);
					pym_q <= mag33(py_w);
					dxs_q <= dx_w[32];
					dys_q <= dy_w[32];
					pxs_q <= px_w[32];
					pys_q <= py_w[32];
					if (dx_w == '0 && dy_w == '0) begin
						stat_q  <= ST_ZERO_SEG;
						state_q <= S_DONE;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					len2_q  <= {1'b0, prod_q};
					state_q <= S_M3;
				end
				S_M3: begin
					len2_q  <= len2_q + {1'b0, prod_q};
					state_q <= S_M4;
				end
				S_M4: begin
					t1_q    <= prod_q;
					state_q <= S_DOT;
				end
				S_DOT: begin
					if (dneg_w || dot_w == '0) begin
						t_q     <= '0;
						state_q <= S_LX;
					end else if (dot_w >= len2_q) begin
						t_q     <= 17'h10000;
						state_q <= S_LX;
					end else begin
						rem_q     <= {1'b0, dot_w};
						t_q       <= '0;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_sh >= {1'b0, len2_q}) begin
						rem_q <= rem_sh - {1'b0, len2_q};
						t_q   <= {t_q[15:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						t_q   <= {t_q[15:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 4'hF) begin
						state_q <= S_LX;
					end
				end
				S_LX: state_q <= S_LY;
				S_LY: begin
					cx_q    <= lerp(sx_q, dxs_q, prod_q);
					state_q <= S_CY;
				end
				S_CY: begin
					cy_q    <= lerp(sy_q, dys_q, prod_q);
					axm_q   <= mag33({qx_q[31], qx_q} - {cx_q[31], cx_q});
					state_q <= S_Q1;
				end
				S_Q1: begin
					aym_q   <= mag33({qy_q[31], qy_q} - {cy_q[31], cy_q});
					state_q <= S_Q2;
				end
				S_Q2: begin
					d2_q    <= {1'b0, prod_q};
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!have_q || d2_w < best_d2_q) begin
						have_q    <= 1'b1;
						best_d2_q <= d2_w;
						best_i_q  <= seg_q[AddrW-1:0];
						best_t_q  <= t_q;
						bcx_q     <= cx_q;
						bcy_q     <= cy_q;
						bsx_q     <= sx_q;
						bsy_q     <= sy_q;
						bex_q     <= ex_q;
						bey_q     <= ey_q;
					end
					if (seg_nxt == segs_q) begin
						sq_v_q   <= (!have_q || d2_w < best_d2_q) ? {1'b0, d2_w}
							: {1'b0, best_d2_q};
						sq_rem_q <= '0;
						root_q   <= '0;
						sq_cnt_q <= '0;
						stat_q   <= ST_OK;
						state_q  <= S_SQRT;
					end else begin
						seg_q   <= seg_nxt;
						sx_q    <= ex_q;
						sy_q    <= ey_q;
						state_q <= S_RD;
					end
				end
				S_SQRT: begin
					sq_v_q <= {sq_v_q[65:0], 2'b00};
					if (sq_rem_sh >= sq_trial) begin
						sq_rem_q <= sq_rem_sh - sq_trial;
						root_q   <= {root_q[32:0], 1'b1};
					end else begin
						sq_rem_q <= sq_rem_sh;
						root_q   <= {root_q[32:0], 1'b0};
					end
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 6'd33) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: if (!res_valid || res_ready) begin
					res_valid <= 1'b1;
					state_q   <= S_IDLE;
					if (stat_q == ST_OK && have_q) begin
						res <= '{status: stat_q, seg_idx: best_i_q,
							seg_param: best_t_q, closest_x: bcx_q, closest_y: bcy_q,
							distance: dist_w, start_x: bsx_q, start_y: bsy_q,
							end_x: bex_q, end_y: bey_q};
					end else begin
						res <= '{status: stat_q, default: '0};
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
